>>> rtl/kswh_pkg.sv
// Shared types and constants for the k-th shortest walk block.
// Used by kswh_cell, kswh_heap_chain and kth_shortest_walk_heap_top.
`default_nettype none
package kswh_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = 10;
    localparam int EDGE_DEPTH = 4096;
    localparam int EIDX_W     = 12;
    localparam int EFILL_W    = 13;
    localparam int LINK_W     = EIDX_W + 1;
    localparam int HEAP_DEPTH = 4096;
    localparam int HFILL_W    = 13;
    localparam int RANK_DEPTH = 1024;
    localparam int RIDX_W     = 10;
    localparam int RCNT_W     = 11;
    localparam int LEN_W      = 48;
    localparam int WT_W       = 30;
    localparam int KNODE_W    = NODE_W + 1;
    localparam int KEY_W      = LEN_W + KNODE_W;

    // empty link: top bit set
    localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {EIDX_W{1'b0}}};
    // empty cell: larger than any real key (real keys have node msb clear)
    localparam logic [KEY_W-1:0]  KEY_EMPTY = {KEY_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // heap order: length first, node second, so the packed word compares directly
    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [KNODE_W-1:0] node;
    } t_key;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        t_key key;
    } t_heap_ctl;

endpackage
`default_nettype wire

>>> rtl/kswh_cell.sv
// One cell of the sorted priority chain: holds a single heap key.
// Depends on kswh_pkg.
`default_nettype none
module kswh_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  kswh_pkg::t_heap_ctl i_ctl,
    input  kswh_pkg::t_key      i_prev_key,
    input  wire                 i_prev_lt,
    input  kswh_pkg::t_key      i_next_key,
    output kswh_pkg::t_key      o_key,
    output logic                o_lt
);

    kswh_pkg::t_key r_key;
    kswh_pkg::t_key n_key;

    // new key sorts strictly before this cell
    assign o_lt  = i_ctl.key < r_key;
    assign o_key = r_key;

    // insert: take left neighbor if new key goes further left, else new key here if it sorts before this cell
    always_comb begin
        n_key = r_key;
        if (i_ctl.push) begin
            if (i_prev_lt) begin
                n_key = i_prev_key;
            end else if (o_lt) begin
                n_key = i_ctl.key;
            end
        end else if (i_ctl.pop) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_key <= kswh_pkg::KEY_EMPTY;
        end else begin
            r_key <= n_key;
        end
    end

endmodule
`default_nettype wire

>>> rtl/kswh_heap_chain.sv
// Bounded min-priority queue as a row of sorted cells plus a fill count.
// Depends on kswh_pkg and kswh_cell.
`default_nettype none
module kswh_heap_chain (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  kswh_pkg::t_heap_ctl i_ctl,
    output kswh_pkg::t_key      o_head,
    output logic                o_nonempty,
    output logic                o_dropped
);

    localparam int D = kswh_pkg::HEAP_DEPTH;

    logic [kswh_pkg::HFILL_W-1:0] r_fill;
    logic                         r_drop;
    logic                         w_full;
    kswh_pkg::t_heap_ctl          w_ctl;
    kswh_pkg::t_key               w_key [D];
    logic                         w_lt  [D];

    assign w_full     = r_fill == kswh_pkg::HFILL_W'(D);
    assign o_nonempty = r_fill != '0;
    assign o_head     = w_key[0];
    assign o_dropped  = r_drop;

    // a push into a full queue is dropped, a pop from an empty queue is ignored
    always_comb begin
        w_ctl      = i_ctl;
        w_ctl.push = i_ctl.push && !w_full;
        w_ctl.pop  = i_ctl.pop && o_nonempty;
    end

    for (genvar g = 0; g < D; g++) begin : g_cell
        kswh_pkg::t_key w_prev;
        kswh_pkg::t_key w_next;
        logic           w_plt;
        if (g == 0) begin : g_first
            assign w_prev = kswh_pkg::KEY_EMPTY;
            assign w_plt  = 1'b0;
        end else begin : g_mid
            assign w_prev = w_key[g-1];
            assign w_plt  = w_lt[g-1];
        end
        if (g == D - 1) begin : g_last
            assign w_next = kswh_pkg::KEY_EMPTY;
        end else begin : g_body
            assign w_next = w_key[g+1];
        end
        kswh_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev_key (w_prev),
            .i_prev_lt  (w_plt),
            .i_next_key (w_next),
            .o_key      (w_key[g]),
            .o_lt       (w_lt[g])
        );
    end

    // fill count and sticky drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_fill <= '0;
            r_drop <= 1'b0;
        end else begin
            if (w_ctl.push) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_ctl.pop) begin
                r_fill <= r_fill - 1'b1;
            end
            if (i_ctl.push && w_full) begin
                r_drop <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/kth_shortest_walk_heap_top.sv
// Top level: command sequencer, adjacency lists, answer store, output register.
// Depends on kswh_pkg and kswh_heap_chain.
//
// channel | dir | tdata fields (low bit up)                          | tuser
// s_axis  | in  | src_node[9:0] dst_node[19:10] edge_weight[49:20]    | cmd[1:0]
//         |     | rank_k[60:50], zero fill to 64                      |
// m_axis  | out | walk_length[47:0] heap_ran_empty[48] push_dropped[49]| none
//         |     | zero fill to 56                                     |
//
// One item at a time. Add edge: store and push the edge, and link the old tail when the
// source list already has edges; an ignored add and an unused command leave the block
// idle, a clear starts the clear pass. Query: for each newly expanded rank, pop the head
// and push its out-edges (one queue insert per cycle), or store an empty answer on an
// empty queue. After reset and after each clear, a pass empties the list heads/tails.
// An answer waits in the output register; a later query stalls until it is taken.
`default_nettype none
module kth_shortest_walk_heap_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // src_node, dst_node, edge_weight, rank_k
    input  wire  [1:0]  i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [55:0] o_m_tdata    // walk_length, heap_ran_empty, push_dropped
);

    localparam int LW = kswh_pkg::LINK_W;
    localparam int EW = kswh_pkg::EIDX_W;
    localparam int NW = kswh_pkg::NODE_W;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CLR   = 12'b0000_0000_0010,
        ST_ARD   = 12'b0000_0000_0100,
        ST_AWR   = 12'b0000_0000_1000,
        ST_ALNK  = 12'b0000_0001_0000,
        ST_QCHK  = 12'b0000_0010_0000,
        ST_POP   = 12'b0000_0100_0000,
        ST_HEAD  = 12'b0000_1000_0000,
        ST_EPUSH = 12'b0001_0000_0000,
        ST_ANS   = 12'b0010_0000_0000,
        ST_RANS  = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } t_state;

    // memories
    logic [2*LW-1:0]               list_mem [kswh_pkg::NODE_COUNT];
    logic [NW+kswh_pkg::WT_W-1:0]  edge_mem [kswh_pkg::EDGE_DEPTH];
    logic [LW-1:0]                 next_mem [kswh_pkg::EDGE_DEPTH];
    logic [kswh_pkg::LEN_W:0]      ans_mem  [kswh_pkg::RANK_DEPTH];

    t_state                        r_state, n_state;
    logic [NW-1:0]                 r_src, n_src;
    logic [NW-1:0]                 r_dst, n_dst;
    logic [kswh_pkg::WT_W-1:0]     r_wt, n_wt;
    logic [kswh_pkg::RCNT_W-1:0]   r_k, n_k;
    logic [kswh_pkg::EFILL_W-1:0]  r_efill, n_efill;
    logic [EW-1:0]                 r_e, n_e;
    logic [EW-1:0]                 r_tail, n_tail;
    logic [kswh_pkg::LEN_W-1:0]    r_len, n_len;
    logic                          r_empty, n_empty;
    logic [kswh_pkg::RCNT_W-1:0]   r_done, n_done;
    logic [NW-1:0]                 r_clr, n_clr;
    logic                          r_ovalid, n_ovalid;
    logic [55:0]                   r_odata, n_odata;

    logic [2*LW-1:0]               r_list_q;
    logic [NW+kswh_pkg::WT_W-1:0]  r_edge_q;
    logic [LW-1:0]                 r_next_q;
    logic [kswh_pkg::LEN_W:0]      r_ans_q;

    // memory port controls
    logic [NW-1:0]                 w_list_ra, w_list_wa;
    logic                          w_list_we;
    logic [2*LW-1:0]               w_list_wd;
    logic [EW-1:0]                 w_e_ra, w_next_wa;
    logic                          w_next_we, w_edge_we;
    logic [LW-1:0]                 w_next_wd;
    logic                          w_ans_we;

    kswh_pkg::t_heap_ctl           w_hctl;
    kswh_pkg::t_key                w_head;
    logic                          w_nonempty, w_dropped;

    logic                          w_acc;
    logic [LW-1:0]                 w_lhead, w_ltail;
    logic [kswh_pkg::LEN_W:0]      w_sum;
    logic [kswh_pkg::LEN_W-1:0]    w_sat;
    logic [kswh_pkg::RCNT_W-1:0]   w_kin;

    assign o_s_tready = r_state == ST_IDLE;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    assign w_lhead = r_list_q[2*LW-1:LW];
    assign w_ltail = r_list_q[LW-1:0];
    assign w_kin   = i_s_tdata[60:50];

    // walk length plus edge weight, saturated
    assign w_sum = {1'b0, r_len} + (kswh_pkg::LEN_W+1)'(r_edge_q[kswh_pkg::WT_W-1:0]);
    assign w_sat = w_sum[kswh_pkg::LEN_W] ? '1 : w_sum[kswh_pkg::LEN_W-1:0];

    kswh_heap_chain u_heap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_hctl),
        .o_head     (w_head),
        .o_nonempty (w_nonempty),
        .o_dropped  (w_dropped)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_src    = r_src;
        n_dst    = r_dst;
        n_wt     = r_wt;
        n_k      = r_k;
        n_efill  = r_efill;
        n_e      = r_e;
        n_tail   = r_tail;
        n_len    = r_len;
        n_empty  = r_empty;
        n_done   = r_done;
        n_clr    = r_clr;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;

        w_list_ra = r_src;
        w_list_we = 1'b0;
        w_list_wa = r_src;
        w_list_wd = {kswh_pkg::LINK_NONE, kswh_pkg::LINK_NONE};
        w_e_ra    = '0;
        w_edge_we = 1'b0;
        w_next_we = 1'b0;
        w_next_wa = r_efill[EW-1:0];
        w_next_wd = kswh_pkg::LINK_NONE;
        w_ans_we  = 1'b0;

        w_hctl.push     = 1'b0;
        w_hctl.pop      = 1'b0;
        w_hctl.clear    = 1'b0;
        w_hctl.key.len  = kswh_pkg::LEN_W'(r_wt);
        w_hctl.key.node = {1'b0, r_dst};

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_src = i_s_tdata[9:0];
                    n_dst = i_s_tdata[19:10];
                    n_wt  = i_s_tdata[49:20];
                    if (w_kin == '0) begin
                        n_k = kswh_pkg::RCNT_W'(1);
                    end else if (32'(w_kin) > kswh_pkg::RANK_DEPTH) begin
                        n_k = kswh_pkg::RCNT_W'(kswh_pkg::RANK_DEPTH);
                    end else begin
                        n_k = w_kin;
                    end
                    unique case (kswh_pkg::t_cmd'(i_s_tuser))
                        kswh_pkg::CMD_CLEAR: begin
                            w_hctl.clear = 1'b1;
                            n_efill      = '0;
                            n_done       = '0;
                            n_clr        = '0;
                            n_state      = ST_CLR;
                        end
                        kswh_pkg::CMD_ADD: begin
                            if (32'(i_s_tdata[9:0]) < kswh_pkg::NODE_COUNT &&
                                32'(i_s_tdata[19:10]) < kswh_pkg::NODE_COUNT &&
                                32'(r_efill) < kswh_pkg::EDGE_DEPTH) begin
                                n_state = ST_ARD;
                            end
                        end
                        kswh_pkg::CMD_QUERY: n_state = ST_QCHK;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            // empty every adjacency list, one node per cycle
            ST_CLR: begin
                w_list_we = 1'b1;
                w_list_wa = r_clr;
                n_clr     = r_clr + 1'b1;
                if (32'(r_clr) == kswh_pkg::NODE_COUNT - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ARD: begin
                w_list_ra = r_src;
                n_state   = ST_AWR;
            end
            // append edge, update list, push its weight
            ST_AWR: begin
                w_edge_we   = 1'b1;
                w_next_we   = 1'b1;
                w_list_we   = 1'b1;
                w_list_wa   = r_src;
                w_list_wd   = {w_lhead[LW-1] ? {1'b0, r_efill[EW-1:0]} : w_lhead,
                               {1'b0, r_efill[EW-1:0]}};
                w_hctl.push = 1'b1;
                n_e         = r_efill[EW-1:0];
                n_tail      = w_ltail[EW-1:0];
                n_efill     = r_efill + 1'b1;
                n_state     = w_ltail[LW-1] ? ST_IDLE : ST_ALNK;
            end
            ST_ALNK: begin
                w_next_we = 1'b1;
                w_next_wa = r_tail;
                w_next_wd = {1'b0, r_e};
                n_state   = ST_IDLE;
            end
            ST_QCHK: begin
                if (r_done < r_k) begin
                    if (w_nonempty) begin
                        n_state = ST_POP;
                    end else begin
                        n_len   = '0;
                        n_empty = 1'b1;
                        n_state = ST_ANS;
                    end
                end else begin
                    n_state = ST_RANS;
                end
            end
            ST_POP: begin
                w_hctl.pop = 1'b1;
                n_len      = w_head.len;
                n_empty    = 1'b0;
                w_list_ra  = w_head.node[NW-1:0];
                n_state    = ST_HEAD;
            end
            ST_HEAD: begin
                w_e_ra  = w_lhead[EW-1:0];
                n_state = w_lhead[LW-1] ? ST_ANS : ST_EPUSH;
            end
            // one out-edge per cycle: push, then fetch the next edge
            ST_EPUSH: begin
                w_hctl.push     = 1'b1;
                w_hctl.key.len  = w_sat;
                w_hctl.key.node = {1'b0, r_edge_q[NW+kswh_pkg::WT_W-1:kswh_pkg::WT_W]};
                w_e_ra          = r_next_q[EW-1:0];
                if (r_next_q[LW-1]) begin
                    n_state = ST_ANS;
                end
            end
            ST_ANS: begin
                w_ans_we = 1'b1;
                n_done   = r_done + 1'b1;
                n_state  = ST_QCHK;
            end
            ST_RANS: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {6'd0, w_dropped, r_ans_q};
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory ports, registered reads
    always_ff @(posedge i_clk) begin
        if (w_list_we) begin
            list_mem[w_list_wa] <= w_list_wd;
        end
        r_list_q <= list_mem[w_list_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_edge_we) begin
            edge_mem[r_efill[EW-1:0]] <= {r_dst, r_wt};
        end
        r_edge_q <= edge_mem[w_e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            next_mem[w_next_wa] <= w_next_wd;
        end
        r_next_q <= next_mem[w_e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ans_we) begin
            ans_mem[r_done[kswh_pkg::RIDX_W-1:0]] <= {r_empty, r_len};
        end
        r_ans_q <= ans_mem[r_k[kswh_pkg::RIDX_W-1:0] - 1'b1];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_efill  <= '0;
            r_done   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_efill  <= n_efill;
            r_done   <= n_done;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_wt    <= n_wt;
        r_k     <= n_k;
        r_e     <= n_e;
        r_tail  <= n_tail;
        r_len   <= n_len;
        r_empty <= n_empty;
        r_odata <= n_odata;
    end

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for kth_shortest_walk_heap_top: directed and random stimulus
// with an in-bench walk-length predictor. Depends on rtl/kswh_pkg.sv and the top level.
`timescale 1ns / 100ps
module testbench;

    localparam int LIMIT     = 200000;
    localparam int HOLD_LEN  = 400;
    localparam logic [47:0] LEN_SAT = 48'hFFFF_FFFF_FFFF;

    // packed from the top bit down: push_dropped, heap_ran_empty, walk_length
    typedef struct packed {
        logic        dropped;
        logic        ran_empty;
        logic [47:0] len;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = kswh_pkg::CMD_NONE;
    logic        m_tready = 1'b0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [55:0] o_m_tdata;

    kth_shortest_walk_heap_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // src_node, dst_node, edge_weight, rank_k
        .i_s_tuser  (s_tuser),    // cmd
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)   // walk_length, heap_ran_empty, push_dropped
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---- predictor state ----
    int          g_dst   [kswh_pkg::EDGE_DEPTH];
    int          g_wt    [kswh_pkg::EDGE_DEPTH];
    int          g_next  [kswh_pkg::EDGE_DEPTH];
    int          g_edges;
    int          g_head  [kswh_pkg::NODE_COUNT];
    int          g_tail  [kswh_pkg::NODE_COUNT];
    logic [47:0] pq_len  [kswh_pkg::HEAP_DEPTH];
    int          pq_node [kswh_pkg::HEAP_DEPTH];
    int          pq_fill;
    logic [47:0] rank_len   [kswh_pkg::RANK_DEPTH];
    logic        rank_empty [kswh_pkg::RANK_DEPTH];
    int          ranks_done;
    logic        overflowed;

    t_answer     pending_answers[$];
    int          errors = 0;
    int          n_sent = 0;
    int          idle_cnt = 0;
    bit          steady = 0;
    logic        hold_req = 1'b0;

    function automatic bit pq_less(int a, int b);
        if (pq_len[a] != pq_len[b]) return pq_len[a] < pq_len[b];
        return pq_node[a] < pq_node[b];
    endfunction

    function automatic void pq_swap(int a, int b);
        logic [47:0] tl;
        int tn;
        tl = pq_len[a]; tn = pq_node[a];
        pq_len[a] = pq_len[b]; pq_node[a] = pq_node[b];
        pq_len[b] = tl; pq_node[b] = tn;
    endfunction

    function automatic void pq_push(int node, logic [47:0] len);
        int i;
        int p;
        if (pq_fill >= kswh_pkg::HEAP_DEPTH) begin
            overflowed = 1'b1;
            return;
        end
        i = pq_fill;
        pq_fill++;
        pq_len[i] = len;
        pq_node[i] = node;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!pq_less(i, p)) break;
            pq_swap(i, p);
            i = p;
        end
    endfunction

    function automatic void graph_clear();
        g_edges = 0;
        pq_fill = 0;
        ranks_done = 0;
        overflowed = 1'b0;
        for (int i = 0; i < kswh_pkg::NODE_COUNT; i++) begin
            g_head[i] = -1;
            g_tail[i] = -1;
        end
    endfunction

    // pop the shortest open walk and extend it along every out-edge of its end node
    function automatic void expand_rank();
        logic [47:0] len;
        logic [48:0] sum;
        int node, e, i, l, r, m;
        len = '0;
        rank_empty[ranks_done] = 1'b1;
        if (pq_fill > 0) begin
            node = pq_node[0];
            len = pq_len[0];
            pq_fill--;
            pq_len[0] = pq_len[pq_fill];
            pq_node[0] = pq_node[pq_fill];
            i = 0;
            forever begin
                l = 2 * i + 1; r = l + 1; m = i;
                if (l < pq_fill && pq_less(l, m)) m = l;
                if (r < pq_fill && pq_less(r, m)) m = r;
                if (m == i) break;
                pq_swap(i, m);
                i = m;
            end
            rank_empty[ranks_done] = 1'b0;
            e = g_head[node];
            while (e >= 0) begin
                sum = {1'b0, len} + 49'(g_wt[e]);
                pq_push(g_dst[e], sum[48] ? LEN_SAT : sum[47:0]);
                e = g_next[e];
            end
        end
        rank_len[ranks_done] = len;
        ranks_done++;
    endfunction

    function automatic void predict_walks(kswh_pkg::t_cmd c, int src, int dst, int wt,
                                          int rank);
        int k;
        t_answer a;
        case (c)
            kswh_pkg::CMD_CLEAR: graph_clear();
            kswh_pkg::CMD_ADD: begin
                if (g_edges < kswh_pkg::EDGE_DEPTH) begin
                    g_dst[g_edges] = dst;
                    g_wt[g_edges] = wt;
                    g_next[g_edges] = -1;
                    if (g_tail[src] >= 0) g_next[g_tail[src]] = g_edges;
                    else g_head[src] = g_edges;
                    g_tail[src] = g_edges;
                    g_edges++;
                    pq_push(dst, 48'(wt));
                end
            end
            kswh_pkg::CMD_QUERY: begin
                k = (rank == 0) ? 1 :
                    (rank > kswh_pkg::RANK_DEPTH ? kswh_pkg::RANK_DEPTH : rank);
                while (ranks_done < k) expand_rank();
                a.len = rank_len[k - 1];
                a.ran_empty = rank_empty[k - 1];
                a.dropped = overflowed;
                pending_answers = {pending_answers, a};
            end
            default: ;
        endcase
    endfunction

    // ---- sender ----
    task automatic send_item(kswh_pkg::t_cmd c, int src, int dst, int wt, int rank);
        int gap;
        if (!steady && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {3'b000, 11'(rank), 30'(wt), 10'(dst), 10'(src)};
        do @(posedge i_clk); while (!o_s_tready);
        // the block sees only the field widths
        predict_walks(c, src & 32'h3FF, dst & 32'h3FF, wt & 32'h3FFF_FFFF, rank & 32'h7FF);
        n_sent++;
    endtask

    task automatic add_edge(int src, int dst, int wt);
        send_item(kswh_pkg::CMD_ADD, src, dst, wt, 0);
    endtask

    task automatic query(int rank);
        send_item(kswh_pkg::CMD_QUERY, 0, 0, 0, rank);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // ---- receiver and checker ----
    int hold_left = 0;
    always @(posedge i_clk) begin
        t_answer exp_a;
        t_answer got;
        if (hold_req && hold_left == 0) hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
        end
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = o_m_tdata[49:0];
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, exp none got %h", $time, got);
                errors++;
            end else begin
                exp_a = pending_answers.pop_front();
                if (got.len !== exp_a.len)
                    $display("%0t: walk_length exp %0d got %0d", $time, exp_a.len, got.len);
                if (got.ran_empty !== exp_a.ran_empty)
                    $display("%0t: heap_ran_empty exp %b got %b", $time,
                             exp_a.ran_empty, got.ran_empty);
                if (got.dropped !== exp_a.dropped)
                    $display("%0t: push_dropped exp %b got %b", $time,
                             exp_a.dropped, got.dropped);
                if (got !== exp_a) errors++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---- tests ----
    task automatic test_empty_heap();
        send_item(kswh_pkg::CMD_CLEAR, 0, 0, 0, 0);
        query(1);
        query(0);        // rank zero acts as rank one
        query(2047);     // saturates to the deepest rank
        send_item(kswh_pkg::CMD_NONE, 1023, 1023, 30'h3FFF_FFFF, 2047);
        query(3);
    endtask

    task automatic test_small_graph();
        send_item(kswh_pkg::CMD_CLEAR, 0, 0, 0, 0);
        add_edge(0, 1, 0);
        add_edge(1, 1023, 30'h3FFF_FFFF);
        add_edge(1023, 0, 1);
        add_edge(0, 0, 5);                // self loop
        add_edge(1, 2, 7);
        query(1);
        query(4);
        query(2);                         // cached rank
        add_edge(2, 0, 3);                // only affects ranks not yet expanded
        query(9);
        send_item(kswh_pkg::CMD_NONE, 0, 0, 0, 1);
        query(40);
    endtask

    // self loops on one node grow the heap until pushes are dropped
    task automatic test_heap_overflow();
        send_item(kswh_pkg::CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 40; i++) add_edge(5, 5, $urandom_range(1000));
        query(50);
        query(200);
        query(1024);
        query(1);
    endtask

    // sparse random graph sent with no idling on either side
    task automatic test_steady();
        steady = 1;
        send_item(kswh_pkg::CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 120; i++)
            add_edge($urandom_range(1023), $urandom_range(1023), $urandom());
        query(1);
        query(700);
        query(1024);
        wait_drained();
        steady = 0;
    endtask

    task automatic test_backpressure();
        send_item(kswh_pkg::CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++) add_edge(i % 3, (i + 1) % 3, $urandom_range(50));
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int i = 1; i <= 12; i++) query(i);
        wait_drained();
    endtask

    // well-formed graph sessions with random content plus some noise
    task automatic test_random();
        int span, base, n_edges, n_q, rank;
        while (n_sent < 1000) begin
            span = $urandom_range(15, 2);
            base = ($urandom_range(9) == 0) ? 1023 - span : $urandom_range(1023 - span);
            if ($urandom_range(9) != 0) send_item(kswh_pkg::CMD_CLEAR, 0, 0, 0, 0);
            n_edges = $urandom_range(25, 4);
            for (int i = 0; i < n_edges; i++)
                add_edge(base + $urandom_range(span), base + $urandom_range(span),
                         ($urandom_range(3) == 0) ? $urandom() : $urandom_range(100));
            n_q = $urandom_range(10, 3);
            for (int i = 0; i < n_q; i++) begin
                case ($urandom_range(29))
                    0: send_item(kswh_pkg::CMD_NONE, $urandom_range(1023),
                                 $urandom_range(1023), $urandom(), $urandom_range(2047));
                    1: add_edge(base + $urandom_range(span), base, $urandom());
                    2: query($urandom_range(2047));
                    default: begin
                        rank = $urandom_range(64);
                        query(rank);
                    end
                endcase
            end
        end
    endtask

    initial begin
        graph_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_heap();
        test_small_graph();
        test_heap_overflow();
        test_backpressure();
        test_steady();
        test_random();
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

>>> kth_shortest_walk_heap_top.f
rtl/kswh_pkg.sv
rtl/kswh_cell.sv
rtl/kswh_heap_chain.sv
rtl/kth_shortest_walk_heap_top.sv
verif/testbench.sv
